FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/pie_pkg.sv
// ----------------------------------------------------------------------------
// pie_pkg
// Shared types and codes for the positional insert/erase list.
// ----------------------------------------------------------------------------
package pie_pkg;

    // command codes
    localparam logic [2:0] OP_APPEND    = 3'd0;
    localparam logic [2:0] OP_PREPEND   = 3'd1;
    localparam logic [2:0] OP_INSERT    = 3'd2;
    localparam logic [2:0] OP_DROP_TAIL = 3'd3;
    localparam logic [2:0] OP_DROP_HEAD = 3'd4;
    localparam logic [2:0] OP_ERASE     = 3'd5;

    // wide enough for any cell index or count up to the largest capacity
    localparam int POS_W = 7;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_INS,
        MODE_DEL,
        MODE_ROT
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t       mode;
        logic [POS_W-1:0] pos;
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage

FILE: hw/rtl/pie_cmd_if.sv
// ----------------------------------------------------------------------------
// pie_cmd_if
// Command channel: valid/ready with op, value and position.
// ----------------------------------------------------------------------------
interface pie_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [4:0]         position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

FILE: hw/rtl/pie_res_if.sv
// ----------------------------------------------------------------------------
// pie_res_if
// Result channel: valid/ready with one list element and its flags.
// ----------------------------------------------------------------------------
interface pie_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element_value;
    logic [3:0]         element_index;
    logic [4:0]         count;
    logic               accepted;
    logic               is_empty;
    logic               is_last;

    modport source (output valid, output element_value, output element_index,
                    output count, output accepted, output is_empty, output is_last,
                    input ready);
    modport sink   (input valid, input element_value, input element_index,
                    input count, input accepted, input is_empty, input is_last,
                    output ready);
endinterface

FILE: hw/rtl/pie_cell.sv
// ----------------------------------------------------------------------------
// pie_cell
// One list slot: holds, shifts up, shifts down or rotates by its own index.
// ----------------------------------------------------------------------------
module pie_cell
    import pie_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic               clk,
    input  cell_cmd_t          cmd,
    input  logic signed [31:0] new_value,
    input  logic signed [31:0] left_value,
    input  logic signed [31:0] right_value,
    input  logic signed [31:0] head_value,
    output logic signed [31:0] value
);

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        case (cmd.mode)
            MODE_INS:
            begin
                if (MY_IDX > cmd.pos)
                    value_next = left_value;
                else if (MY_IDX == cmd.pos)
                    value_next = new_value;
            end
            MODE_DEL:
            begin
                if (MY_IDX >= cmd.pos)
                    value_next = right_value;
            end
            MODE_ROT:
            begin
                // pos is the last occupied slot; the head value wraps around into it
                if (MY_IDX == cmd.pos)
                    value_next = head_value;
                else if (MY_IDX < cmd.pos)
                    value_next = right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: hw/rtl/positional_insert_erase_list_top.sv
// ----------------------------------------------------------------------------
// positional_insert_erase_list_top
// Ordered list of signed values held in a row of cells, dumped after each
// command.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | handshake
//  cmd     | in  | op, value, position                             | valid/ready
//  res     | out | element_value, element_index, count, accepted,  | valid/ready
//          |     | is_empty, is_last                               |
//
// A command is applied to the cell row in the cycle it is taken; then the
// row rotates once per result beat, head cell to the output register, giving
// one beat per element, or a lone empty marker beat when the list is empty.
// A stall on res freezes the rotation; the next command is taken while the
// final beat still waits in the output register.
// Reset clears the count and the control; cell contents are left as they are.
// ----------------------------------------------------------------------------
module positional_insert_erase_list_top
    import pie_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    pie_cmd_if.sink   cmd,
    pie_res_if.source res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(CAPACITY);
    localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [KW-1:0]      k_reg, k_next;
    logic               ok_reg, ok_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg, out_value_next;
    logic [3:0]         out_index_reg, out_index_next;
    logic [4:0]         out_count_reg, out_count_next;
    logic               out_ok_reg, out_ok_next;
    logic               out_empty_reg, out_empty_next;
    logic               out_last_reg, out_last_next;

    cell_cmd_t          cell_cmd;
    logic signed [31:0] cell_value [CAPACITY];

    logic [POS_W-1:0]   pos_p, cnt_p;
    logic               full, empty, out_free, is_last_item;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [31:0] left_value;
            logic signed [31:0] right_value;
            if (gi == 0)
            begin : g_first
                assign left_value = cmd.value;
            end
            else
            begin : g_mid_l
                assign left_value = cell_value[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_value = cell_value[gi];
            end
            else
            begin : g_mid_r
                assign right_value = cell_value[gi+1];
            end
            pie_cell #(.IDX(gi)) u_cell (
                .clk         (clk),
                .cmd         (cell_cmd),
                .new_value   (cmd.value),
                .left_value  (left_value),
                .right_value (right_value),
                .head_value  (cell_value[0]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    assign pos_p        = POS_W'(cmd.position);
    assign cnt_p        = POS_W'(cnt_reg);
    assign full         = (cnt_p == CAP_P);
    assign empty        = (cnt_reg == '0);
    assign out_free     = !out_valid_reg || res.ready;
    assign is_last_item = empty || (POS_W'(k_reg) == cnt_p - POS_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_count_next = out_count_reg;
        out_ok_next    = out_ok_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;
        cell_cmd.mode  = MODE_HOLD;
        cell_cmd.pos   = '0;
        cmd.ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    ok_next = 1'b0;
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            ok_next      = !full;
                            cell_cmd.mode = MODE_INS;
                            cell_cmd.pos = cnt_p;
                        end
                        OP_PREPEND:
                        begin
                            ok_next      = !full;
                            cell_cmd.mode = MODE_INS;
                            cell_cmd.pos = '0;
                        end
                        OP_INSERT:
                        begin
                            ok_next      = !full && (pos_p <= cnt_p);
                            cell_cmd.mode = MODE_INS;
                            cell_cmd.pos = pos_p;
                        end
                        OP_DROP_TAIL:
                        begin
                            ok_next      = !empty;
                            cell_cmd.mode = MODE_DEL;
                            cell_cmd.pos = cnt_p - POS_W'(1);
                        end
                        OP_DROP_HEAD:
                        begin
                            ok_next      = !empty;
                            cell_cmd.mode = MODE_DEL;
                            cell_cmd.pos = '0;
                        end
                        OP_ERASE:
                        begin
                            ok_next      = !empty && (pos_p < cnt_p);
                            cell_cmd.mode = MODE_DEL;
                            cell_cmd.pos = pos_p;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                    if (!ok_next)
                        cell_cmd.mode = MODE_HOLD;
                    else if (cell_cmd.mode == MODE_INS)
                        cnt_next = cnt_reg + CW'(1);
                    else
                        cnt_next = cnt_reg - CW'(1);
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = empty ? 32'sd0 : cell_value[0];
                    out_index_next = 4'(k_reg);
                    out_count_next = 5'(cnt_reg);
                    out_ok_next    = ok_reg;
                    out_empty_next = empty;
                    out_last_next  = is_last_item;
                    if (!empty)
                    begin
                        // rotate so the next element reaches the head cell
                        cell_cmd.mode = MODE_ROT;
                        cell_cmd.pos  = cnt_p - POS_W'(1);
                    end
                    if (is_last_item)
                    begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + KW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_count_reg <= out_count_next;
        out_ok_reg    <= out_ok_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.element_value = out_value_reg;
    assign res.element_index = out_index_reg;
    assign res.count         = out_count_reg;
    assign res.accepted      = out_ok_reg;
    assign res.is_empty      = out_empty_reg;
    assign res.is_last       = out_last_reg;

endmodule

FILE: hw/rtl/pie_checker.sv
// ----------------------------------------------------------------------------
// pie_checker
// Port-level checks on the list block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pie_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_element_value,
    input logic [3:0]  res_element_index,
    input logic [4:0]  res_count,
    input logic        res_is_empty,
    input logic        res_is_last
);

    // a stalled beat keeps its payload
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_element_value) && $stable(res_element_index) && $stable(res_is_last))

    // the empty marker is a lone final beat with a zero count
    `ASSERT_SAME(a_empty_last, clk, rst_n, res_valid && res_is_empty, res_is_last && (res_count == 5'd0))

    // the final element of a non-empty dump sits at count - 1
    `ASSERT_SAME(a_last_index, clk, rst_n, res_valid && res_is_last && !res_is_empty, res_element_index == 4'(res_count - 5'd1))

    // no new command is taken while a dump is still in progress
    `ASSERT_SAME(a_busy_dump, clk, rst_n, res_valid && !res_is_last, !cmd_ready)

endmodule

bind positional_insert_erase_list_top pie_checker u_pie_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_ready         (cmd.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_element_value (res.element_value),
    .res_element_index (res.element_index),
    .res_count         (res.count),
    .res_is_empty      (res.is_empty),
    .res_is_last       (res.is_last)
);

FILE: bench/tb_positional_insert_erase_list_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_insert_erase_list_top
// Drives list commands into the positional insert/erase list and checks every
// dumped element against a shadow list kept in the bench, under random idling
// on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_positional_insert_erase_list_top
    import pie_pkg::*;
();

    localparam int          LIST_DEPTH    = 16;
    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam logic [2:0]  OP_RESERVED_A = 3'd6;
    localparam logic [2:0]  OP_RESERVED_B = 3'd7;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [4:0]         position;
    } list_cmd_t;

    typedef struct {
        logic signed [31:0] value;
        logic [3:0]         index;
        logic [4:0]         count;
        logic               accepted;
        logic               empty;
        logic               last;
    } list_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    pie_cmd_if cmd ();
    pie_res_if res ();

    positional_insert_erase_list_top #(
        .CAPACITY (LIST_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    // shadow list and the beats it should dump
    logic signed [31:0] list_model [LIST_DEPTH];
    int unsigned        list_len = 0;
    list_beat_t         expected_dump [$];
    list_cmd_t          pending_cmds [$];

    int unsigned send_idle_pct = 20;
    int unsigned recv_idle_pct = 88;
    int unsigned hold_req      = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic bit model_put(int unsigned at, logic signed [31:0] v);
        if (list_len >= LIST_DEPTH || at > list_len)
            return 1'b0;
        for (int unsigned i = list_len; i > at; i--)
            list_model[i] = list_model[i - 1];
        list_model[at] = v;
        list_len++;
        return 1'b1;
    endfunction

    function automatic bit model_take(int unsigned at);
        if (list_len == 0 || at >= list_len)
            return 1'b0;
        for (int unsigned i = at; i + 1 < list_len; i++)
            list_model[i] = list_model[i + 1];
        list_len--;
        return 1'b1;
    endfunction

    // apply one command to the shadow list, then queue the full dump
    function automatic void predict_dump(logic [2:0] op, logic signed [31:0] v,
                                         logic [4:0] pos);
        bit         ok;
        list_beat_t b;
        ok = 1'b0;
        case (op)
            OP_APPEND:  ok = model_put(list_len, v);
            OP_PREPEND: ok = model_put(0, v);
            OP_INSERT:  ok = model_put(32'(pos), v);
            OP_DROP_TAIL:
            begin
                if (list_len != 0)
                    ok = model_take(list_len - 1);
            end
            OP_DROP_HEAD: ok = model_take(0);
            OP_ERASE:     ok = model_take(32'(pos));
            default:      ok = 1'b0;
        endcase
        b.accepted = ok;
        if (list_len == 0)
        begin
            b.value = '0;
            b.index = '0;
            b.count = '0;
            b.empty = 1'b1;
            b.last  = 1'b1;
            expected_dump = {expected_dump, b};
        end
        else
        begin
            for (int unsigned k = 0; k < list_len; k++)
            begin
                b.value = list_model[k];
                b.index = k[3:0];
                b.count = list_len[4:0];
                b.empty = 1'b0;
                b.last  = (k + 1 == list_len);
                expected_dump = {expected_dump, b};
            end
        end
    endfunction

    // command driver: one beat offered at a time, held until taken
    always @(posedge clk)
    begin : drive_cmd
        list_cmd_t nxt;
        if (!rst_n)
        begin
            cmd.valid    <= 1'b0;
            cmd.op       <= OP_APPEND;
            cmd.value    <= '0;
            cmd.position <= '0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                predict_dump(cmd.op, cmd.value, cmd.position);
            if (!cmd.valid || cmd.ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_cmds[0];
                    pending_cmds.delete(0);
                    cmd.valid    <= 1'b1;
                    cmd.op       <= nxt.op;
                    cmd.value    <= nxt.value;
                    cmd.position <= nxt.position;
                end
                else
                begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            res.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_dump
        list_beat_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_dump.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected beat value=%0d index=%0d count=%0d",
                             $time, res.element_value, res.element_index, res.count);
            end
            else
            begin
                want = expected_dump[0];
                expected_dump.delete(0);
                if (res.element_value !== want.value || res.element_index !== want.index ||
                    res.count !== want.count || res.accepted !== want.accepted ||
                    res.is_empty !== want.empty || res.is_last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: beat mismatch exp val=%0d idx=%0d cnt=%0d acc=%0b %s",
                                 $time, want.value, want.index, want.count,
                                 want.accepted, "");
                        $display("    exp emp=%0b last=%0b", want.empty, want.last);
                        $display("    got val=%0d idx=%0d cnt=%0d acc=%0b emp=%0b last=%0b",
                                 res.element_value, res.element_index, res.count,
                                 res.accepted, res.is_empty, res.is_last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("positional_insert_erase_list_top test failed");
            $finish;
        end
    end

    task automatic queue_cmd(logic [2:0] op, logic signed [31:0] v, logic [4:0] pos);
        list_cmd_t c;
        c.op       = op;
        c.value    = v;
        c.position = pos;
        pending_cmds = {pending_cmds, c};
    endtask

    // grow_pct of puts, shrink_pct of takes, the rest any op and position
    task automatic queue_random(int n, int unsigned grow_pct, int unsigned shrink_pct);
        int unsigned r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < grow_pct)
            begin
                case ($urandom_range(2))
                    0:       queue_cmd(OP_APPEND, $urandom, 5'($urandom_range(31)));
                    1:       queue_cmd(OP_PREPEND, $urandom, 5'($urandom_range(31)));
                    default: queue_cmd(OP_INSERT, $urandom, 5'($urandom_range(1)));
                endcase
            end
            else if (r < grow_pct + shrink_pct)
            begin
                case ($urandom_range(2))
                    0:       queue_cmd(OP_DROP_TAIL, $urandom, 5'($urandom_range(31)));
                    1:       queue_cmd(OP_DROP_HEAD, $urandom, 5'($urandom_range(31)));
                    default: queue_cmd(OP_ERASE, $urandom, 5'($urandom_range(1)));
                endcase
            end
            else
            begin
                queue_cmd(3'($urandom_range(7)), $urandom, 5'($urandom_range(31)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmd.valid || expected_dump.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);

        // empty list corners, extremes, append via insert, out-of-range cases
        queue_cmd(OP_DROP_TAIL,  32'sd0, 5'd0);
        queue_cmd(OP_DROP_HEAD,  32'sd0, 5'd0);
        queue_cmd(OP_ERASE,      32'sd0, 5'd0);
        queue_cmd(OP_INSERT,     32'sd7, 5'd1);
        queue_cmd(OP_INSERT,     32'sh8000_0000, 5'd0);
        queue_cmd(OP_APPEND,     32'sh7fff_ffff, 5'd0);
        queue_cmd(OP_PREPEND,    -32'sd1, 5'd0);
        queue_cmd(OP_INSERT,     32'sd0, 5'd3);
        queue_cmd(OP_INSERT,     32'sh5a5a_5a5a, 5'd2);
        queue_cmd(OP_ERASE,      32'sd0, 5'd31);
        queue_cmd(OP_ERASE,      32'sd0, 5'd5);
        queue_cmd(OP_RESERVED_A, -32'sd1, 5'd16);
        queue_cmd(OP_RESERVED_B, 32'sh1234_5678, 5'd1);
        queue_cmd(OP_ERASE,      32'sd0, 5'd2);
        queue_cmd(OP_DROP_HEAD,  32'sd0, 5'd0);
        queue_cmd(OP_DROP_TAIL,  32'sd0, 5'd0);
        queue_cmd(OP_ERASE,      32'sd0, 5'd16);
        queue_cmd(OP_ERASE,      32'sd0, 5'd0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 88;
                end
                1:
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // stall the output while commands keep coming
                    hold_req++;
                end
            endcase
            queue_random(17, 100, 0);
            queue_random(5, 45, 35);
            queue_random(12, 0, 100);
            wait_drained();
        end

        repeat (40) @(negedge clk);
        if (mismatches == 0 && expected_dump.size() == 0)
            $display("positional_insert_erase_list_top test passed");
        else
            $display("positional_insert_erase_list_top test failed");
        $finish;
    end

endmodule
